FILE: design/clrp_pkg.sv
// clrp_pkg: shared constants and types for the cpu list range parser
// no dependencies; used by the channel interfaces, the parser and the top level
`default_nettype none

package clrp_pkg;

   // item and result field widths
   localparam int BYTE_W   = 8;
   localparam int OUT_BITS = 32;
   localparam int COUNT_W  = 6;

   // ascii codes the parser reacts to
   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_DASH    = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

   // decimal base for number accumulation
   localparam logic [3:0] DEC_BASE = 4'd10;

   // what the parser hands over at the end of a text
   typedef struct packed {
      logic [OUT_BITS-1:0] mask;
      logic                stopped;
   } clrp_result_type;

endpackage

`default_nettype wire

FILE: design/clrp_req_if.sv
// clrp_req_if: input channel carrying one text byte per item
// depends on clrp_pkg
`default_nettype none

interface clrp_req_if
   import clrp_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: design/clrp_rsp_if.sv
// clrp_rsp_if: result channel carrying the mask, its popcount and the stop flag
// depends on clrp_pkg
`default_nettype none

interface clrp_rsp_if
   import clrp_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] cpu_mask;
   logic [COUNT_W-1:0]  set_count;
   logic                stopped_early;

   modport source (output valid, output cpu_mask, output set_count, output stopped_early,
                   input ready);
   modport sink   (input valid, input cpu_mask, input set_count, input stopped_early,
                   output ready);
endinterface

`default_nettype wire

FILE: design/cpu_list_range_parser.sv
// cpu_list_range_parser: top level, byte register, parser, result stage with popcount
// depends on clrp_pkg, clrp_req_if, clrp_rsp_if and clrp_parser
//
//   channel  | dir | payload                                  | when
//   ---------+-----+------------------------------------------+------------------------
//   req_ch   | in  | in_byte[7:0], last_byte                  | one text byte per item
//   rsp_ch   | out | cpu_mask[31:0], set_count[5:0], stopped_ | one item per text, on
//            |     | early                                    | the byte marked last
//
// one byte is taken every cycle while the result side keeps up
// a result follows its last byte through the byte register, the parser update into
// the hand-off register and the popcount into the output register
// synchronous reset returns the parser to item start with an empty mask
// a stalled result holds the output register; bytes keep flowing through the
// parser until a second result waits in the hand-off register and a byte waits
// in the byte register, then req_ch stalls
`default_nettype none

module cpu_list_range_parser
   import clrp_pkg::*;
#(
   parameter int MASK_BITS = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   clrp_req_if.sink    req_ch,
   clrp_rsp_if.source  rsp_ch
);

   // byte register
   logic              s1_valid_ff;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_last_ff;

   // hand-off register between parser and popcount
   logic              p2_valid_ff;
   clrp_result_type   p2_result_ff;

   // output register
   logic                out_valid_ff;
   logic [OUT_BITS-1:0] out_mask_ff;
   logic [COUNT_W-1:0]  out_count_ff;
   logic                out_stopped_ff;

   logic              out_load, p2_load, s1_load, parse_step;
   clrp_result_type   parse_result;
   logic [COUNT_W-1:0] count_in;

   // popcount as a tree of adders, one level per pass
   function automatic logic [COUNT_W-1:0] popcount(input logic [OUT_BITS-1:0] v);
      logic [1:0] l1 [16];
      logic [2:0] l2 [8];
      logic [3:0] l3 [4];
      logic [4:0] l4 [2];
      for (int i = 0; i < 16; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
      for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
      for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
      for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
      return {1'b0, l4[0]} + {1'b0, l4[1]};
   endfunction

   // each stage moves when it is empty or the stage after it moves
   assign out_load   = !out_valid_ff || rsp_ch.ready;
   assign p2_load    = !p2_valid_ff || out_load;
   assign s1_load    = !s1_valid_ff || p2_load;
   assign parse_step = s1_valid_ff && p2_load;

   assign req_ch.ready = s1_load;

   clrp_parser #(
      .MASK_BITS (MASK_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (parse_step),
      .in_byte   (s1_byte_ff),
      .last_byte (s1_last_ff),
      .result    (parse_result)
   );

   assign count_in = popcount(p2_result_ff.mask);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (p2_load) begin
            // only the last byte of a text produces a result
            p2_valid_ff <= parse_step && s1_last_ff;
         end
         if (out_load) begin
            out_valid_ff <= p2_valid_ff;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_byte_ff <= req_ch.in_byte;
         s1_last_ff <= req_ch.last_byte;
      end
      if (p2_load) begin
         p2_result_ff <= parse_result;
      end
      if (out_load) begin
         out_mask_ff    <= p2_result_ff.mask;
         out_count_ff   <= count_in;
         out_stopped_ff <= p2_result_ff.stopped;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.cpu_mask      = out_mask_ff;
   assign rsp_ch.set_count     = out_count_ff;
   assign rsp_ch.stopped_early = out_stopped_ff;

endmodule

`default_nettype wire

FILE: design/clrp_parser.sv
// clrp_parser: per-byte parse state machine and range mask accumulation
// depends on clrp_pkg
`default_nettype none

module clrp_parser
   import clrp_pkg::*;
#(
   parameter int MASK_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [BYTE_W-1:0] in_byte,
   input  wire logic              last_byte,
   output clrp_result_type        result
);

   localparam int VW = $clog2(MASK_BITS + 1);
   localparam int NW = VW + 4;
   localparam logic [VW-1:0] SAT = VW'(MASK_BITS);

   typedef enum logic [2:0] {
      PH_START,
      PH_FIRST,
      PH_DASH,
      PH_SKIP,
      PH_DONE,
      PH_STOP
   } phase_type;

   phase_type            phase_ff, phase_in, fin_phase;
   logic [VW-1:0]        start_ff, start_in;
   logic [VW-1:0]        end_ff, end_in;
   logic                 seen_ff, seen_in;
   logic [MASK_BITS-1:0] mask_ff, mask_in, range_bits;
   logic                 commit;
   logic                 is_digit;
   logic [BYTE_W-1:0]    diff;
   logic [3:0]           digit;

   // value * 10 + digit, saturating at the mask size
   function automatic logic [VW-1:0] accumulate(input logic [VW-1:0] v, input logic [3:0] d);
      logic [NW-1:0] n;
      n = NW'(v) * NW'(DEC_BASE) + NW'(d);
      return (n > NW'(MASK_BITS)) ? SAT : n[VW-1:0];
   endfunction

   assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
   assign diff     = in_byte - CH_ZERO;
   assign digit    = diff[3:0];

   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      end_in   = end_ff;
      seen_in  = seen_ff;
      commit   = 1'b0;

      case (phase_ff)
         PH_START: begin
            if (in_byte == CH_NEWLINE) begin
               phase_in = PH_DONE;
            end else if (is_digit) begin
               start_in = accumulate('0, digit);
               phase_in = PH_FIRST;
            end else begin
               phase_in = PH_STOP;
            end
         end
         PH_FIRST: begin
            if (is_digit) begin
               start_in = accumulate(start_ff, digit);
            end else if (in_byte == CH_DASH) begin
               end_in   = '0;
               seen_in  = 1'b0;
               phase_in = PH_DASH;
            end else begin
               end_in   = start_ff;
               commit   = 1'b1;
               phase_in = (in_byte == CH_COMMA) ? PH_START : PH_SKIP;
            end
         end
         PH_DASH: begin
            if (is_digit) begin
               end_in  = accumulate(end_ff, digit);
               seen_in = 1'b1;
            end else if (!seen_ff) begin
               phase_in = PH_STOP;
            end else begin
               commit   = 1'b1;
               phase_in = (in_byte == CH_COMMA) ? PH_START : PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (in_byte == CH_COMMA) begin
               phase_in = PH_START;
            end
         end
         default: begin
         end
      endcase

      // end of text closes a number still open
      fin_phase = phase_in;
      if (last_byte) begin
         if (phase_in == PH_FIRST) begin
            end_in    = start_in;
            commit    = 1'b1;
            fin_phase = PH_DONE;
         end else if (phase_in == PH_DASH) begin
            if (seen_in) begin
               commit    = 1'b1;
               fin_phase = PH_DONE;
            end else begin
               fin_phase = PH_STOP;
            end
         end
      end

      // at most one range closes per byte; each bit compares on its own
      for (int i = 0; i < MASK_BITS; i++) begin
         range_bits[i] = commit && (VW'(i) >= start_in) && (VW'(i) <= end_in);
      end
      mask_in = mask_ff | range_bits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         start_ff <= '0;
         end_ff   <= '0;
         seen_ff  <= 1'b0;
         mask_ff  <= '0;
      end else if (step) begin
         if (last_byte) begin
            phase_ff <= PH_START;
            start_ff <= '0;
            end_ff   <= '0;
            seen_ff  <= 1'b0;
            mask_ff  <= '0;
         end else begin
            phase_ff <= phase_in;
            start_ff <= start_in;
            end_ff   <= end_in;
            seen_ff  <= seen_in;
            mask_ff  <= mask_in;
         end
      end
   end

   // report the low bits of the mask, zero filled when the mask is narrow
   generate
      for (genvar g = 0; g < OUT_BITS; g++) begin : g_out
         if (g < MASK_BITS) begin : g_bit
            assign result.mask[g] = mask_in[g];
         end else begin : g_zero
            assign result.mask[g] = 1'b0;
         end
      end
   endgenerate

   assign result.stopped = (fin_phase == PH_STOP);

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// tb_top: self-checking bench for cpu_list_range_parser, streams cpu list text bytes
// depends on clrp_pkg, clrp_req_if, clrp_rsp_if and the parser top level
module tb_top
   import clrp_pkg::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   // cpu indices at or above this count set no bit
   localparam int CPU_LIMIT   = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TEXT_BYTES  = 1100;

   // parser phases as the bench tracks them
   typedef enum logic [2:0] {
      ST_ITEM_START,
      ST_FIRST_NUM,
      ST_AFTER_DASH,
      ST_SKIP_TO_COMMA,
      ST_FINISHED,
      ST_STOPPED
   } list_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } text_byte_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] mask;
      logic [COUNT_W-1:0]  count;
      logic                stopped;
   } cpu_set_type;

   logic clock;
   logic reset;

   clrp_req_if req_ch ();
   clrp_rsp_if rsp_ch ();

   cpu_list_range_parser #(
      .MASK_BITS(CPU_LIMIT)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // text bytes waiting to be sent, and cpu sets still owed by the block
   text_byte_type pending_bytes[$];
   cpu_set_type   expected_sets[$];

   int total_bytes;
   int bytes_accepted;
   int fail_count;
   int cycle_count;

   // sender burst shaping
   int burst_left;
   int gap_left;

   // receiver stall shaping
   int stall_mode;
   int stall_beat;

   // shadow parser state
   list_phase_type list_phase;
   int          lo_index;
   int          hi_index;
   bit          saw_digit;
   logic [OUT_BITS-1:0] listed_mask;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // shadow parser
   // ---------------------------------------------------------------

   // one more decimal digit, pinned at the cpu limit
   function automatic int add_digit(int value, int digit);
      int n;
      n = value * 10 + digit;
      return (n > CPU_LIMIT) ? CPU_LIMIT : n;
   endfunction

   // or lo..hi into the mask, clipping hi to the top bit; reversed ranges add nothing
   function automatic void set_cpu_range();
      int top;
      top = (hi_index >= CPU_LIMIT) ? CPU_LIMIT - 1 : hi_index;
      for (int i = lo_index; i <= top; i++) listed_mask[i] = 1'b1;
   endfunction

   function automatic void clear_list_state();
      list_phase  = ST_ITEM_START;
      lo_index    = 0;
      hi_index    = 0;
      saw_digit   = 1'b0;
      listed_mask = '0;
   endfunction

   // advance the shadow parser by one accepted byte; on the last byte the
   // finished cpu set goes into the expected queue
   function automatic void absorb_byte(logic [BYTE_W-1:0] c, logic last);
      bit          is_digit;
      int          digit;
      cpu_set_type done_set;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      digit    = int'(c) - int'(CH_ZERO);
      case (list_phase)
         ST_ITEM_START: begin
            // newline where an item should start ends the list cleanly
            if (c == CH_NEWLINE) begin
               list_phase = ST_FINISHED;
            end else if (is_digit) begin
               lo_index   = add_digit(0, digit);
               list_phase = ST_FIRST_NUM;
            end else begin
               list_phase = ST_STOPPED;
            end
         end
         ST_FIRST_NUM: begin
            if (is_digit) begin
               lo_index = add_digit(lo_index, digit);
            end else if (c == CH_DASH) begin
               hi_index   = 0;
               saw_digit  = 1'b0;
               list_phase = ST_AFTER_DASH;
            end else begin
               hi_index = lo_index;
               set_cpu_range();
               list_phase = (c == CH_COMMA) ? ST_ITEM_START : ST_SKIP_TO_COMMA;
            end
         end
         ST_AFTER_DASH: begin
            if (is_digit) begin
               hi_index  = add_digit(hi_index, digit);
               saw_digit = 1'b1;
            end else if (!saw_digit) begin
               list_phase = ST_STOPPED;
            end else begin
               set_cpu_range();
               list_phase = (c == CH_COMMA) ? ST_ITEM_START : ST_SKIP_TO_COMMA;
            end
         end
         ST_SKIP_TO_COMMA: begin
            if (c == CH_COMMA) list_phase = ST_ITEM_START;
         end
         default: begin
         end
      endcase

      if (last) begin
         // a number still open at the end of the text is committed
         if (list_phase == ST_FIRST_NUM) begin
            hi_index = lo_index;
            set_cpu_range();
            list_phase = ST_FINISHED;
         end else if (list_phase == ST_AFTER_DASH) begin
            if (saw_digit) begin
               set_cpu_range();
               list_phase = ST_FINISHED;
            end else begin
               list_phase = ST_STOPPED;
            end
         end
         done_set.mask    = listed_mask;
         done_set.count   = COUNT_W'($countones(listed_mask));
         done_set.stopped = (list_phase == ST_STOPPED);
         expected_sets.push_back(done_set);
         clear_list_state();
      end
   endfunction

   // ---------------------------------------------------------------
   // text generation
   // ---------------------------------------------------------------

   function automatic void push_char(logic [BYTE_W-1:0] c);
      text_byte_type t;
      t.data = c;
      t.last = 1'b0;
      pending_bytes.push_back(t);
   endfunction

   function automatic void add_chars(string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endfunction

   // flag the newest byte as the end of its text
   function automatic void close_text();
      text_byte_type t;
      t      = pending_bytes.pop_back();
      t.last = 1'b1;
      pending_bytes.push_back(t);
   endfunction

   // any byte except a comma, so skipped tails stay tails
   function automatic logic [BYTE_W-1:0] junk_byte();
      logic [BYTE_W-1:0] c;
      do c = BYTE_W'($urandom_range(0, 255)); while (c == CH_COMMA);
      return c;
   endfunction

   // mostly in-range indices, some just past the limit, some long or zero-padded
   function automatic void add_number();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         add_chars($sformatf("%0d", $urandom_range(0, CPU_LIMIT - 1)));
      end else if (pick < 80) begin
         add_chars($sformatf("%0d", $urandom_range(CPU_LIMIT, CPU_LIMIT + 8)));
      end else if (pick < 92) begin
         add_chars($sformatf("%0d", $urandom_range(0, 99999)));
      end else begin
         repeat ($urandom_range(1, 3)) add_chars("0");
         add_chars($sformatf("%0d", $urandom_range(0, 40)));
      end
   endfunction

   function automatic void make_random_text();
      int elems;
      if ($urandom_range(0, 9) == 0) begin
         // pure noise, every byte value possible
         repeat ($urandom_range(1, 6)) push_char(BYTE_W'($urandom_range(0, 255)));
         close_text();
         return;
      end
      elems = $urandom_range(1, 6);
      for (int e = 0; e < elems; e++) begin
         if (e > 0) add_chars(",");
         // now and then an item with no number at all
         if ($urandom_range(0, 24) == 0) begin
            case ($urandom_range(0, 2))
               0: add_chars(",");
               1: add_chars("-");
               default: push_char(junk_byte());
            endcase
         end
         add_number();
         if ($urandom_range(0, 2) == 0) begin
            add_chars("-");
            // a dash with nothing after it, or a non-digit after it
            if ($urandom_range(0, 19) == 0) begin
               if ($urandom_range(0, 1) == 0) push_char(junk_byte());
            end else begin
               add_number();
            end
         end
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) push_char(junk_byte());
         end
      end
      case ($urandom_range(0, 5))
         0: add_chars(",");
         1: begin
            // newline ends the list, the tail is ignored
            add_chars(",\n");
            repeat ($urandom_range(0, 3)) push_char(BYTE_W'($urandom_range(0, 255)));
         end
         default: begin
         end
      endcase
      close_text();
   endfunction

   // ---------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.in_byte   = '0;
      req_ch.last_byte = 1'b0;
      rsp_ch.ready     = 1'b0;
      bytes_accepted   = 0;
      fail_count       = 0;
      cycle_count      = 0;
      burst_left       = $urandom_range(1, 20);
      gap_left         = 0;
      stall_mode       = 0;
      stall_beat       = 0;
      clear_list_state();

      // directed texts
      add_chars("\n");          close_text();   // newline at item start
      add_chars("0,2-5");       close_text();   // plain list
      add_chars("0-40");        close_text();   // full mask, end saturates
      add_chars("9-3,3");                       // reversed range, skipped tail,
      push_char(8'hFF);                         // then a dash with no number
      add_chars(",3-x");        close_text();
      add_chars("4-");          close_text();   // text ends right after a dash
      add_chars(",");           close_text();   // empty first item
      add_chars("1,\n5");       close_text();   // bytes after the newline ignored
      add_chars("2\n");         close_text();   // newline inside an item
      push_char(8'h00);         close_text();   // non-digit at item start
      add_chars("3,");          close_text();   // text ends after a comma
      add_chars("99999,31");    close_text();   // large value, top index

      while (pending_bytes.size() < TEXT_BYTES) make_random_text();
      total_bytes = pending_bytes.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // bytes_accepted moves in the same step as the prediction it causes
      while (bytes_accepted < total_bytes) @(posedge clock);
      while (expected_sets.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0) begin
         $display("cpu_list_range_parser verification clean");
      end else begin
         $display("cpu_list_range_parser verification failed");
      end
      $finish;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cpu_list_range_parser verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // byte driver: bursts of random length with random gaps between
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_bytes
      text_byte_type next_byte;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         // predict on the edge that takes the byte
         if (req_ch.valid && req_ch.ready) begin
            absorb_byte(req_ch.in_byte, req_ch.last_byte);
            bytes_accepted++;
         end
         // only move on once the current item is gone
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0 || pending_bytes.size() == 0) begin
               req_ch.valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end else begin
               next_byte = pending_bytes.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.in_byte   <= next_byte.data;
               req_ch.last_byte <= next_byte.last;
               burst_left--;
               if (burst_left <= 0) begin
                  // some bursts run back to back, some are long
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                           : $urandom_range(1, 24);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // result monitor: checks each cpu set under a stall pattern that changes mode
   // ---------------------------------------------------------------
   always @(posedge clock) begin : watch_sets
      cpu_set_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_sets.size() == 0) begin
               $display("%0t: unexpected result: mask %h count %0d stopped %0b",
                        $time, rsp_ch.cpu_mask, rsp_ch.set_count, rsp_ch.stopped_early);
               fail_count++;
            end else begin
               want = expected_sets.pop_front();
               if (rsp_ch.cpu_mask !== want.mask) begin
                  $display("%0t: cpu_mask expected %h actual %h",
                           $time, want.mask, rsp_ch.cpu_mask);
                  fail_count++;
               end
               if (rsp_ch.set_count !== want.count) begin
                  $display("%0t: set_count expected %0d actual %0d",
                           $time, want.count, rsp_ch.set_count);
                  fail_count++;
               end
               if (rsp_ch.stopped_early !== want.stopped) begin
                  $display("%0t: stopped_early expected %0b actual %0b",
                           $time, want.stopped, rsp_ch.stopped_early);
                  fail_count++;
               end
            end
         end

         stall_beat++;
         if (stall_beat % 97 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ch.ready <= 1'b1;                           // always ready
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));      // coin flip
            2: rsp_ch.ready <= (stall_beat % 4 == 0);          // one in four
            default: rsp_ch.ready <= (stall_beat % 13 < 2);    // long stalls
         endcase
      end
   end

endmodule
